### sv/scse_pkg.sv
// Package for the square channel with sweep and envelope.
// Holds the beat and register types, the codes, the constants and the duty table.
// Used by every module of the block; depends on nothing.
package scse_pkg;

   // Input beat modes.
   localparam logic [1:0] MODE_CYCLES  = 2'd0;
   localparam logic [1:0] MODE_FRAME   = 2'd1;
   localparam logic [1:0] MODE_TRIGGER = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] REG_DUTY_PATTERN      = 3'd0;
   localparam logic [2:0] REG_START_FREQUENCY   = 3'd1;
   localparam logic [2:0] REG_SWEEP_PERIOD      = 3'd2;
   localparam logic [2:0] REG_SWEEP_RSHIFT      = 3'd3;
   localparam logic [2:0] REG_SWEEP_SUBTRACT    = 3'd4;
   localparam logic [2:0] REG_ENVELOPE_INCREASE = 3'd5;
   localparam logic [2:0] REG_ENVELOPE_PERIOD   = 3'd6;
   localparam logic [2:0] REG_LENGTH_ENABLE     = 3'd7;

   // Frame sequencer step that clocks the envelope.
   localparam logic [2:0] STEP_ENVELOPE = 3'd7;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 11;

   localparam logic [10:0] FREQ_MAX      = 11'd2047;
   localparam logic [11:0] FREQ_SPAN     = 12'd2048;
   localparam logic [3:0]  VOLUME_MAX    = 4'd15;
   localparam logic [6:0]  LENGTH_FULL   = 7'd64;
   localparam logic [13:0] ACCUM_MAX     = 14'h3FFF;
   localparam logic [1:0]  DUTY_RESET    = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [9:0] cycles;
      logic [2:0] frame_step;
      logic [3:0] start_volume;
      logic [6:0] start_length;
   } req_type;

   typedef struct packed {
      logic [3:0]  level;
      logic        channel_on;
      logic [10:0] frequency;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  duty_pattern;
      logic [10:0] start_frequency;
      logic [2:0]  sweep_period;
      logic [2:0]  sweep_rshift;
      logic        sweep_subtract;
      logic        envelope_increase;
      logic [2:0]  envelope_period;
      logic        length_enable;
   } cfg_type;

   // Duty waveform bit for a pattern at a waveform position.
   function automatic logic duty_bit(input logic [1:0] pattern, input logic [2:0] pos);
      logic [7:0] bits;
      unique case (pattern)
         2'd0: bits = 8'h80;
         2'd1: bits = 8'h81;
         2'd2: bits = 8'hE1;
         default: bits = 8'h7E;
      endcase
      return bits[pos];
   endfunction

   // Sweep target: frequency plus or minus itself shifted right; bit 11 flags overflow.
   function automatic logic [11:0] sweep_calc(input logic [10:0] freq,
                                              input logic [2:0] shift,
                                              input logic subtract);
      logic [10:0] delta;
      delta = freq >> shift;
      if (subtract) begin
         return {1'b0, freq - delta};
      end
      return {1'b0, freq} + {1'b0, delta};
   endfunction

endpackage

### sv/scse_csr.sv
// Configuration registers of the square channel.
// Takes writes from the register port and presents them as one struct.
// Depends on scse_pkg.
module scse_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [scse_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [scse_pkg::CsrDataWidth-1:0]     csr_data,
   output scse_pkg::cfg_type                     cfg
);

   scse_pkg::cfg_type cfg_ff, cfg_in;

   // Decode the register index and update the addressed field.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            scse_pkg::REG_DUTY_PATTERN:      cfg_in.duty_pattern      = csr_data[1:0];
            scse_pkg::REG_START_FREQUENCY:   cfg_in.start_frequency   = csr_data[10:0];
            scse_pkg::REG_SWEEP_PERIOD:      cfg_in.sweep_period      = csr_data[2:0];
            scse_pkg::REG_SWEEP_RSHIFT:      cfg_in.sweep_rshift      = csr_data[2:0];
            scse_pkg::REG_SWEEP_SUBTRACT:    cfg_in.sweep_subtract    = csr_data[0];
            scse_pkg::REG_ENVELOPE_INCREASE: cfg_in.envelope_increase = csr_data[0];
            scse_pkg::REG_ENVELOPE_PERIOD:   cfg_in.envelope_period   = csr_data[2:0];
            scse_pkg::REG_LENGTH_ENABLE:     cfg_in.length_enable     = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{duty_pattern: scse_pkg::DUTY_RESET, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/scse_core.sv
// Channel state and its update for a single input beat.
// Holds timer, sweep, length and envelope state and forms the result fields.
// Depends on scse_pkg.
module scse_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  scse_pkg::req_type    item,
   input  scse_pkg::cfg_type    cfg,
   output scse_pkg::rsp_type    result
);

   logic        active_ff, active_in;
   logic [10:0] freq_ff, freq_in;
   logic        sweep_active_ff, sweep_active_in;
   logic [2:0]  sweep_cd_ff, sweep_cd_in;
   logic [6:0]  length_ff, length_in;
   logic        env_active_ff, env_active_in;
   logic [2:0]  env_cd_ff, env_cd_in;
   logic [3:0]  volume_ff, volume_in;
   logic [2:0]  duty_pos_ff, duty_pos_in;
   logic [13:0] accum_ff, accum_in;

   logic [11:0] sweep_first;
   logic [10:0] sweep_clamped;
   logic [11:0] sweep_second;
   logic [11:0] sweep_trigger;
   logic [2:0]  sweep_cd_dec;
   logic [2:0]  env_cd_dec;
   logic [6:0]  length_dec;
   logic [14:0] accum_sum;
   logic [13:0] accum_sat;
   logic [13:0] timer_period;

   // Sweep targets: a step computes, clamps and rechecks; a trigger checks once.
   assign sweep_first   = scse_pkg::sweep_calc(freq_ff, cfg.sweep_rshift, cfg.sweep_subtract);
   assign sweep_clamped = sweep_first[11] ? scse_pkg::FREQ_MAX : sweep_first[10:0];
   assign sweep_second  = scse_pkg::sweep_calc(sweep_clamped, cfg.sweep_rshift,
                                               cfg.sweep_subtract);
   assign sweep_trigger = scse_pkg::sweep_calc(cfg.start_frequency, cfg.sweep_rshift,
                                               cfg.sweep_subtract);

   // Counter decrements; the sweep and length counters stop at zero.
   assign sweep_cd_dec = (sweep_cd_ff != 3'd0) ? sweep_cd_ff - 3'd1 : 3'd0;
   assign env_cd_dec   = env_cd_ff - 3'd1;
   assign length_dec   = (length_ff != 7'd0) ? length_ff - 7'd1 : 7'd0;

   // Waveform timer: saturating accumulate against (2048 - frequency) * 4.
   assign accum_sum    = {1'b0, accum_ff} + {5'd0, item.cycles};
   assign accum_sat    = accum_sum[14] ? scse_pkg::ACCUM_MAX : accum_sum[13:0];
   assign timer_period = {scse_pkg::FREQ_SPAN - {1'b0, freq_ff}, 2'b00};

   // Next state for the beat in the input register.
   always_comb begin
      active_in       = active_ff;
      freq_in         = freq_ff;
      sweep_active_in = sweep_active_ff;
      sweep_cd_in     = sweep_cd_ff;
      length_in       = length_ff;
      env_active_in   = env_active_ff;
      env_cd_in       = env_cd_ff;
      volume_in       = volume_ff;
      duty_pos_in     = duty_pos_ff;
      accum_in        = accum_ff;
      if (advance) begin
         unique case (item.mode)
            scse_pkg::MODE_CYCLES: begin
               if (active_ff) begin
                  accum_in = accum_sat;
                  if (accum_sat >= timer_period) begin
                     accum_in    = accum_sat - timer_period;
                     duty_pos_in = duty_pos_ff + 3'd1;
                  end
               end
            end
            scse_pkg::MODE_FRAME: begin
               // The frame steps matched below clock the sweep.
               if (item.frame_step[1:0] == 2'b10 && sweep_active_ff &&
                   cfg.sweep_period != 3'd0) begin
                  sweep_cd_in = sweep_cd_dec;
                  if (sweep_cd_dec == 3'd0) begin
                     if (sweep_first[11]) begin
                        active_in = 1'b0;
                     end
                     if (cfg.sweep_rshift != 3'd0) begin
                        freq_in = sweep_clamped;
                        if (sweep_second[11]) begin
                           active_in = 1'b0;
                        end
                     end
                     sweep_cd_in = cfg.sweep_period;
                  end
               end
               // Even steps clock the length counter.
               if (!item.frame_step[0] && cfg.length_enable) begin
                  length_in = length_dec;
                  if (length_dec == 7'd0) begin
                     active_in = 1'b0;
                  end
               end
               // The last step clocks the envelope.
               if (item.frame_step == scse_pkg::STEP_ENVELOPE && env_active_ff) begin
                  env_cd_in = env_cd_dec;
                  if (env_cd_dec == 3'd0) begin
                     if (cfg.envelope_increase) begin
                        if (volume_ff != scse_pkg::VOLUME_MAX) begin
                           volume_in = volume_ff + 4'd1;
                        end else begin
                           env_active_in = 1'b0;
                        end
                     end else begin
                        if (volume_ff != 4'd0) begin
                           volume_in = volume_ff - 4'd1;
                        end else begin
                           env_active_in = 1'b0;
                        end
                     end
                     env_cd_in = cfg.envelope_period;
                  end
               end
            end
            scse_pkg::MODE_TRIGGER: begin
               active_in       = !(cfg.sweep_rshift != 3'd0 && sweep_trigger[11]);
               freq_in         = cfg.start_frequency;
               volume_in       = item.start_volume;
               length_in       = (item.start_length == 7'd0 ||
                                  item.start_length > scse_pkg::LENGTH_FULL) ?
                                 scse_pkg::LENGTH_FULL : item.start_length;
               env_cd_in       = cfg.envelope_period;
               env_active_in   = cfg.envelope_period != 3'd0;
               sweep_cd_in     = cfg.sweep_period;
               sweep_active_in = cfg.sweep_period != 3'd0 || cfg.sweep_rshift != 3'd0;
               accum_in        = '0;
            end
            default: begin
               active_in = active_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         freq_ff         <= '0;
         sweep_active_ff <= 1'b0;
         sweep_cd_ff     <= '0;
         length_ff       <= '0;
         env_active_ff   <= 1'b0;
         env_cd_ff       <= '0;
         volume_ff       <= '0;
         duty_pos_ff     <= '0;
         accum_ff        <= '0;
      end else begin
         active_ff       <= active_in;
         freq_ff         <= freq_in;
         sweep_active_ff <= sweep_active_in;
         sweep_cd_ff     <= sweep_cd_in;
         length_ff       <= length_in;
         env_active_ff   <= env_active_in;
         env_cd_ff       <= env_cd_in;
         volume_ff       <= volume_in;
         duty_pos_ff     <= duty_pos_in;
         accum_ff        <= accum_in;
      end
   end

   // Result fields reflect the state after the beat.
   assign result.level      = (active_in && scse_pkg::duty_bit(cfg.duty_pattern, duty_pos_in)) ?
                              volume_in : 4'd0;
   assign result.channel_on = active_in;
   assign result.frequency  = freq_in;

endmodule

### sv/square_channel_sweep_envelope.sv
// Top level of the square channel with frequency sweep, length counter and envelope.
// Holds the input and result registers around the channel core.
// Depends on scse_pkg, scse_csr and scse_core.
//
// Usage: each beat on the req_ channel is one of three commands: advance the
// waveform timer by the amount given in the beat, run a frame sequencer step, or
// trigger the channel. Every beat produces exactly one beat on the rsp_
// channel carrying the output level, the enable flag and the current
// frequency, all as they stand after that command.
// A beat is taken when valid is high and stall is low. A command sits in the
// input register until it can advance, is applied to the channel state, and
// its result is registered into the result register.
// One command is taken every cycle while the receiver does not stall; the state
// update for a command happens in the same cycle it leaves the input register.
// When the receiver stalls, the result register holds its beat and the input
// register keeps its command; req_stall rises in that same cycle.
// Configuration registers are written through the csr_ port, which is always
// ready; write them only while no command is in flight.
// Reset clears the channel (off, all counters zero), sets duty select to 50%
// and clears all other configuration registers.
module square_channel_sweep_envelope (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  scse_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output scse_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [scse_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [scse_pkg::CsrDataWidth-1:0]     csr_data
);

   logic              req_valid_ff, req_valid_in;
   scse_pkg::req_type req_item_ff, req_item_in;
   logic              rsp_valid_ff, rsp_valid_in;
   scse_pkg::rsp_type rsp_item_ff, rsp_item_in;
   logic              advance;
   scse_pkg::cfg_type cfg;
   scse_pkg::rsp_type core_result;

   assign csr_ready = 1'b1;

   scse_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   scse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   // A held command moves on when the result register is empty or being drained.
   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;

   // Input register loads whenever it is not stalled.
   always_comb begin
      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
         req_item_in  = req_data;
      end
   end

   // Result register loads on advance and holds under stall.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

endmodule

### verif/square_channel_sweep_envelope_test.sv
// Self-checking testbench for the square channel with sweep, length counter and envelope.
// Tracks the channel state in a scoreboard class and compares every result beat with it.
// Depends on scse_pkg and square_channel_sweep_envelope.
`timescale 1ns / 100ps

// Mirrors the channel state and holds the output beats still owed by the block.
class channel_tracker;
   // Configuration as last written.
   bit [1:0]  duty_sel;
   bit [10:0] freq_load;
   bit [2:0]  sweep_len;
   bit [2:0]  sweep_shr;
   bit        sweep_down;
   bit        env_up;
   bit [2:0]  env_len;
   bit        len_gate;

   // Channel state.
   bit        on;
   bit        sweep_run;
   bit        env_run;
   bit [10:0] freq;
   bit [2:0]  sweep_cnt;
   bit [2:0]  env_cnt;
   bit [2:0]  pos;
   bit [6:0]  len_left;
   bit [3:0]  vol;
   bit [13:0] accum;

   bit [7:0]  waves [4];
   scse_pkg::rsp_type outputs_due [$];
   int mismatches;

   function new();
      waves = '{8'h80, 8'h81, 8'hE1, 8'h7E};
      duty_sel = scse_pkg::DUTY_RESET;
      mismatches = 0;
   endfunction

   function int outstanding();
      return outputs_due.size();
   endfunction

   function void set_register(input logic [2:0] index, input int value);
      case (index)
         scse_pkg::REG_DUTY_PATTERN:      duty_sel = value[1:0];
         scse_pkg::REG_START_FREQUENCY:   freq_load = value[10:0];
         scse_pkg::REG_SWEEP_PERIOD:      sweep_len = value[2:0];
         scse_pkg::REG_SWEEP_RSHIFT:      sweep_shr = value[2:0];
         scse_pkg::REG_SWEEP_SUBTRACT:    sweep_down = value[0];
         scse_pkg::REG_ENVELOPE_INCREASE: env_up = value[0];
         scse_pkg::REG_ENVELOPE_PERIOD:   env_len = value[2:0];
         default:                         len_gate = value[0];
      endcase
   endfunction

   // Frequency the sweep would move to; above the 11-bit range means overflow.
   function int sweep_target();
      int f;
      int d;
      f = int'(freq);
      d = f >> sweep_shr;
      return sweep_down ? f - d : f + d;
   endfunction

   function void clock_sweep();
      int target;
      if (!sweep_run || sweep_len == 0) return;
      if (sweep_cnt != 0) sweep_cnt--;
      if (sweep_cnt != 0) return;
      target = sweep_target();
      if (target > int'(scse_pkg::FREQ_MAX)) begin
         on = 1'b0;
         target = int'(scse_pkg::FREQ_MAX);
      end
      // Only a nonzero shift commits the new frequency, and it is checked again.
      if (sweep_shr != 0) begin
         freq = target[10:0];
         if (sweep_target() > int'(scse_pkg::FREQ_MAX)) on = 1'b0;
      end
      sweep_cnt = sweep_len;
   endfunction

   function void clock_length();
      if (!len_gate) return;
      if (len_left != 0) len_left--;
      if (len_left == 0) on = 1'b0;
   endfunction

   function void clock_envelope();
      if (!env_run) return;
      // The countdown is three bits wide, so zero wraps to seven.
      env_cnt = env_cnt - 3'd1;
      if (env_cnt != 0) return;
      if (env_up) begin
         if (vol < scse_pkg::VOLUME_MAX) vol++;
         else env_run = 1'b0;
      end else begin
         if (vol > 0) vol--;
         else env_run = 1'b0;
      end
      env_cnt = env_len;
   endfunction

   // At most one waveform step per beat; the accumulator saturates.
   function void advance(input bit [9:0] n);
      int sum;
      int span;
      if (!on) return;
      sum = int'(accum) + int'(n);
      if (sum > int'(scse_pkg::ACCUM_MAX)) sum = int'(scse_pkg::ACCUM_MAX);
      span = (int'(scse_pkg::FREQ_SPAN) - int'(freq)) * 4;
      if (sum >= span) begin
         sum = sum - span;
         pos++;
      end
      accum = sum[13:0];
   endfunction

   function void retrigger(input bit [3:0] v, input bit [6:0] l);
      on = 1'b1;
      freq = freq_load;
      vol = v;
      len_left = (l == 0 || l > scse_pkg::LENGTH_FULL) ? scse_pkg::LENGTH_FULL : l;
      env_cnt = env_len;
      env_run = env_len != 0;
      sweep_cnt = sweep_len;
      sweep_run = sweep_len != 0 || sweep_shr != 0;
      if (sweep_shr != 0 && sweep_target() > int'(scse_pkg::FREQ_MAX)) on = 1'b0;
      accum = '0;
   endfunction

   // Applies one accepted command beat and queues the output it must produce.
   function void take_command(input scse_pkg::req_type beat);
      scse_pkg::rsp_type due;
      case (beat.mode)
         scse_pkg::MODE_CYCLES: advance(beat.cycles);
         scse_pkg::MODE_FRAME: begin
            // On the frame steps that clock the sweep, it runs ahead of the length counter.
            case (beat.frame_step)
               3'd2, 3'd6: begin
                  clock_sweep();
                  clock_length();
               end
               3'd0, 3'd4: clock_length();
               scse_pkg::STEP_ENVELOPE: clock_envelope();
               default: ;
            endcase
         end
         scse_pkg::MODE_TRIGGER: retrigger(beat.start_volume, beat.start_length);
         default: ;
      endcase
      due.level = (on && waves[duty_sel][pos]) ? vol : 4'd0;
      due.channel_on = on;
      due.frequency = freq;
      outputs_due.push_back(due);
   endfunction

   // Compares one output beat with the oldest one owed.
   function void match_output(input scse_pkg::rsp_type got);
      scse_pkg::rsp_type due;
      if (outputs_due.size() == 0) begin
         $error("output beat with no command pending");
         mismatches++;
         return;
      end
      due = outputs_due.pop_front();
      if (got.level !== due.level) begin
         $error("level: expected %0d, got %0d", due.level, got.level);
         mismatches++;
      end
      if (got.channel_on !== due.channel_on) begin
         $error("channel_on: expected %0d, got %0d", due.channel_on, got.channel_on);
         mismatches++;
      end
      if (got.frequency !== due.frequency) begin
         $error("frequency: expected %0d, got %0d", due.frequency, got.frequency);
         mismatches++;
      end
   endfunction
endclass

module square_channel_sweep_envelope_test;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   scse_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   scse_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [scse_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [scse_pkg::CsrDataWidth-1:0] csr_data = '0;

   channel_tracker board;
   bit sender_calm = 1'b0;
   int tick = 0;

   square_channel_sweep_envelope uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      tick <= tick + 1;
      if (tick == CYCLE_LIMIT) begin
         $display("square_channel_sweep_envelope_test: errors");
         $finish;
      end
   end

   // Every result beat taken by the receiver is checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.match_output(rsp_data);
   end

   // Mostly short idle gaps, a few long ones.
   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Either the lowest, the highest or any value of a field.
   function automatic int pick_field(input int hi);
      case ($urandom_range(0, 3))
         0: return 0;
         1: return hi;
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   // Receiver stalls, with stretches where it takes every beat.
   initial begin
      int hold;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end else begin
            hold = pause_len();
            if (hold != 0) begin
               rsp_stall = 1'b1;
               repeat (hold) @(negedge clock);
            end
            rsp_stall = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
      end
   end

   // A beat of the unused mode with every other field random; the builders below override what matters.
   function automatic scse_pkg::req_type noise_beat();
      scse_pkg::req_type beat;
      beat.mode = MODE_UNUSED;
      beat.cycles = 10'($urandom_range(0, 1023));
      beat.frame_step = 3'($urandom_range(0, 7));
      beat.start_volume = 4'($urandom_range(0, 15));
      beat.start_length = 7'($urandom_range(0, 64));
      return beat;
   endfunction

   function automatic scse_pkg::req_type cycles_beat(input int n);
      scse_pkg::req_type beat;
      beat = noise_beat();
      beat.mode = scse_pkg::MODE_CYCLES;
      beat.cycles = n[9:0];
      return beat;
   endfunction

   function automatic scse_pkg::req_type frame_beat(input int s);
      scse_pkg::req_type beat;
      beat = noise_beat();
      beat.mode = scse_pkg::MODE_FRAME;
      beat.frame_step = s[2:0];
      return beat;
   endfunction

   function automatic scse_pkg::req_type trigger_beat(input int v, input int l);
      scse_pkg::req_type beat;
      beat = noise_beat();
      beat.mode = scse_pkg::MODE_TRIGGER;
      beat.start_volume = v[3:0];
      beat.start_length = l[6:0];
      return beat;
   endfunction

   // Offers one command beat after a random gap, unless the sender is calm, and waits until it is taken.
   task automatic send_beat(input scse_pkg::req_type beat);
      int gap;
      gap = sender_calm ? 0 : pause_len();
      if (gap != 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data = beat;
      do @(posedge clock); while (req_stall);
      board.take_command(beat);
   endtask

   // Ends a burst of commands and waits until every owed result is in.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic put_reg(input logic [2:0] index, input int value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = value[10:0];
      do @(posedge clock); while (!csr_ready);
      board.set_register(index, value);
   endtask

   // Writes all eight registers back to back.
   task automatic load_config(input scse_pkg::cfg_type c);
      put_reg(scse_pkg::REG_DUTY_PATTERN, int'(c.duty_pattern));
      put_reg(scse_pkg::REG_START_FREQUENCY, int'(c.start_frequency));
      put_reg(scse_pkg::REG_SWEEP_PERIOD, int'(c.sweep_period));
      put_reg(scse_pkg::REG_SWEEP_RSHIFT, int'(c.sweep_rshift));
      put_reg(scse_pkg::REG_SWEEP_SUBTRACT, int'(c.sweep_subtract));
      put_reg(scse_pkg::REG_ENVELOPE_INCREASE, int'(c.envelope_increase));
      put_reg(scse_pkg::REG_ENVELOPE_PERIOD, int'(c.envelope_period));
      put_reg(scse_pkg::REG_LENGTH_ENABLE, int'(c.length_enable));
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      scse_pkg::cfg_type setup;
      int fs;
      int r;
      board = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Cycles and steps while off, then a trigger that overflows at once.
      send_beat(cycles_beat(1023));
      send_beat(frame_beat(7));
      setup = '{duty_pattern: 2'd0, start_frequency: 11'd2047, sweep_period: 3'd1,
                sweep_rshift: 3'd1, sweep_subtract: 1'b0, envelope_increase: 1'b1,
                envelope_period: 3'd1, length_enable: 1'b1};
      drain();
      load_config(setup);
      send_beat(trigger_beat(0, 0));
      send_beat(cycles_beat(1023));
      send_beat(frame_beat(2));

      // Lowest frequency, loudest volume, shortest length, then a full-length retrigger.
      setup = '{duty_pattern: 2'd1, start_frequency: 11'd0, sweep_period: 3'd7,
                sweep_rshift: 3'd7, sweep_subtract: 1'b1, envelope_increase: 1'b0,
                envelope_period: 3'd1, length_enable: 1'b1};
      drain();
      load_config(setup);
      send_beat(trigger_beat(15, 1));
      send_beat(cycles_beat(0));
      send_beat(cycles_beat(1023));
      send_beat(frame_beat(7));
      send_beat(frame_beat(1));
      send_beat(frame_beat(3));
      send_beat(frame_beat(5));
      send_beat(frame_beat(4));
      send_beat(trigger_beat(15, 64));
      send_beat(frame_beat(6));
      send_beat(noise_beat());

      // Highest frequency, sweep with no shift overflowing without storing.
      setup = '{duty_pattern: 2'd2, start_frequency: 11'd2047, sweep_period: 3'd2,
                sweep_rshift: 3'd0, sweep_subtract: 1'b0, envelope_increase: 1'b1,
                envelope_period: 3'd0, length_enable: 1'b0};
      drain();
      load_config(setup);
      send_beat(trigger_beat(8, 0));
      send_beat(cycles_beat(4));
      send_beat(cycles_beat(5));
      send_beat(frame_beat(2));
      send_beat(frame_beat(6));
      send_beat(frame_beat(7));
      drain();

      // Envelope period cleared while the envelope runs: the countdown wraps.
      setup = '{duty_pattern: 2'd3, start_frequency: 11'd1000, sweep_period: 3'd0,
                sweep_rshift: 3'd0, sweep_subtract: 1'b0, envelope_increase: 1'b0,
                envelope_period: 3'd1, length_enable: 1'b0};
      setup.envelope_increase = 1'($urandom_range(0, 1));
      load_config(setup);
      send_beat(trigger_beat($urandom_range(4, 11), $urandom_range(0, 64)));
      send_beat(frame_beat(7));
      send_beat(cycles_beat($urandom_range(0, 1023)));
      send_beat(frame_beat(7));
      drain();
      setup.envelope_period = 3'd0;
      load_config(setup);
      repeat (12) begin
         send_beat(frame_beat(7));
         send_beat(cycles_beat($urandom_range(0, 1023)));
      end
      drain();

      // Sweep climbing toward the top while large cycle counts drive the waveform
      // timer, until the channel finally overflows.
      setup = '{duty_pattern: 2'd0, start_frequency: 11'd1536, sweep_period: 3'd1,
                sweep_rshift: 3'd7, sweep_subtract: 1'b0, envelope_increase: 1'b0,
                envelope_period: 3'd0, length_enable: 1'b0};
      setup.duty_pattern = 2'($urandom_range(0, 3));
      load_config(setup);
      send_beat(trigger_beat(15, $urandom_range(0, 64)));
      repeat (45) begin
         send_beat(frame_beat(2));
         repeat (3) send_beat(cycles_beat($urandom_range(1000, 1023)));
      end
      drain();

      // Random settings; each phase triggers, then runs the frame sequencer in
      // order with cycle advances, retriggers and a little noise mixed in.
      repeat (8) begin
         setup.duty_pattern = 2'(pick_field(3));
         setup.start_frequency = ($urandom_range(0, 2) == 0) ?
                                 11'($urandom_range(1900, 2047)) : 11'(pick_field(2047));
         setup.sweep_period = 3'(pick_field(7));
         setup.sweep_rshift = 3'(pick_field(7));
         setup.sweep_subtract = 1'($urandom_range(0, 1));
         setup.envelope_increase = 1'($urandom_range(0, 1));
         setup.envelope_period = 3'(pick_field(7));
         setup.length_enable = 1'($urandom_range(0, 1));
         load_config(setup);
         sender_calm = ($urandom_range(0, 3) == 0);
         send_beat(trigger_beat($urandom_range(0, 15), $urandom_range(0, 64)));
         fs = $urandom_range(0, 7);
         repeat (42) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               send_beat(noise_beat());
            end else if (r < 9) begin
               send_beat(trigger_beat(pick_field(15), pick_field(64)));
            end else if (r < 50) begin
               send_beat(cycles_beat(pick_field(1023)));
            end else if (r < 90) begin
               send_beat(frame_beat(fs));
               fs = (fs + 1) % 8;
            end else begin
               send_beat(frame_beat($urandom_range(0, 7)));
            end
         end
         drain();
      end

      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("square_channel_sweep_envelope_test: clean");
      end else begin
         $display("square_channel_sweep_envelope_test: errors");
      end
      $finish;
   end
endmodule
